>>> rtl/pss_pkg.sv
// shared types, constants and the tanh table for the square/saw voice bank
// no dependencies
package pss_pkg;

    // default number of voices
    localparam int VOICES_DEF = 8;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HZ      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VOLUME  = 3'd4;
    localparam int CFG_DATA_W = 24;

    // register reset values
    localparam logic [15:0] ATTACK_RST  = 16'd149;
    localparam logic [15:0] RELEASE_RST = 16'd30;
    localparam logic [15:0] ALPHA_RST   = 16'd17210;
    localparam logic [23:0] HZ_RST      = 24'd1558252;
    localparam logic [15:0] VOLUME_RST  = 16'd32768;

    // operation codes
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_NOTE_ON  = 2'd1;
    localparam logic [1:0] OP_NOTE_OFF = 2'd2;

    // fixed point constants
    localparam logic [16:0] ENV_ONE       = 17'd65536;
    localparam logic [16:0] ENV_THRESHOLD = 17'd6;
    localparam logic [24:0] GLIDE_COEF    = 25'd328;
    localparam logic [18:0] SQUARE_AMP    = 19'd45875;
    localparam logic [24:0] SAW_GAIN      = 25'd19661;
    localparam logic [14:0] CLIP_MAX      = 15'd32767;

    // shared multiplier operand widths
    localparam int MUL_A_W = 36;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // round(32768 * tanh(k / 8)) for k = 0..32
    function automatic logic [14:0] tanh_lut(input logic [5:0] k);
        logic [14:0] t;
        begin
            case (k)
                6'd0:  t = 15'd0;
                6'd1:  t = 15'd4075;
                6'd2:  t = 15'd8025;
                6'd3:  t = 15'd11743;
                6'd4:  t = 15'd15143;
                6'd5:  t = 15'd18173;
                6'd6:  t = 15'd20813;
                6'd7:  t = 15'd23066;
                6'd8:  t = 15'd24956;
                6'd9:  t = 15'd26519;
                6'd10: t = 15'd27797;
                6'd11: t = 15'd28830;
                6'd12: t = 15'd29660;
                6'd13: t = 15'd30322;
                6'd14: t = 15'd30847;
                6'd15: t = 15'd31262;
                6'd16: t = 15'd31589;
                6'd17: t = 15'd31846;
                6'd18: t = 15'd32048;
                6'd19: t = 15'd32206;
                6'd20: t = 15'd32329;
                6'd21: t = 15'd32426;
                6'd22: t = 15'd32500;
                6'd23: t = 15'd32560;
                6'd24: t = 15'd32606;
                6'd25: t = 15'd32642;
                6'd26: t = 15'd32670;
                6'd27: t = 15'd32691;
                6'd28: t = 15'd32708;
                6'd29: t = 15'd32722;
                6'd30: t = 15'd32732;
                6'd31: t = 15'd32740;
                default: t = 15'd32746;
            endcase
            return t;
        end
    endfunction

endpackage

>>> rtl/pss_mul.sv
// shared signed multiplier with registered product
// depends on pss_pkg for operand widths
module pss_mul
(
    input  logic                                clk,
    input  logic signed [pss_pkg::MUL_A_W-1:0]  a,
    input  logic signed [pss_pkg::MUL_B_W-1:0]  b,
    output logic signed [pss_pkg::MUL_P_W-1:0]  p
);

    // product register
    always_ff @(posedge clk)
    begin
        p <= a * b;
    end

endmodule

>>> rtl/polyphonic_square_saw_synth.sv
// top level of the square/saw voice bank: sequencer, voice state, mixer, soft clip
// depends on pss_pkg and pss_mul
//
// Channels:
//   item (item_valid/item_ready): operation, track, frequency. Note on and note
//   off are taken without leaving idle and give no result. A sample tick gives one
//   sample item on the sample channel (sample_valid/sample_ready).
//   cfg (cfg_valid/cfg_ready): cfg_index selects attack, release, alpha,
//   hz_to_phase or volume; cfg_ready is always high, unknown indexes ignored.
// Tick sequence:
//   a tick visits the voices one after another through one shared multiplier:
//   a sounding voice runs the glide, envelope, phase, saw, lowpass and mix steps,
//   a silent one only the glide and envelope steps; then the soft clip and volume
//   steps follow and the sample is stored, and the next item can be taken in the
//   cycle after that. item_ready is low while a tick is in work.
// Output:
//   the sample sits in an output register; the next items are accepted while it
//   waits, and a following tick holds in its last step until the sample is taken.
// Reset:
//   rst_n clears all voices, the gates and the output valid flag, and loads the
//   register defaults.
module polyphonic_square_saw_synth
#(
    parameter int VOICES = pss_pkg::VOICES_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic [1:0]                         operation,
    input  logic [3:0]                         track,
    input  logic [18:0]                        frequency,
    output logic                               sample_valid,
    input  logic                               sample_ready,
    output logic signed [15:0]                 sample,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pss_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

    typedef enum logic [15:0] {
        S_IDLE    = 16'b0000_0000_0000_0001,
        S_GLIDE   = 16'b0000_0000_0000_0010,
        S_ENV     = 16'b0000_0000_0000_0100,
        S_STEP    = 16'b0000_0000_0000_1000,
        S_PHASE   = 16'b0000_0000_0001_0000,
        S_SAW     = 16'b0000_0000_0010_0000,
        S_RAW     = 16'b0000_0000_0100_0000,
        S_LPMUL   = 16'b0000_0000_1000_0000,
        S_LPUPD   = 16'b0000_0001_0000_0000,
        S_MIXMUL  = 16'b0000_0010_0000_0000,
        S_MIXACC  = 16'b0000_0100_0000_0000,
        S_CLIP    = 16'b0000_1000_0000_0000,
        S_CLIPMUL = 16'b0001_0000_0000_0000,
        S_CLIPY   = 16'b0010_0000_0000_0000,
        S_VOL     = 16'b0100_0000_0000_0000,
        S_OUT     = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic [15:0] attack_reg, release_reg, alpha_reg, volume_reg;
    logic [23:0] hz_reg;

    // voice state
    logic               gate_reg   [VOICES];
    logic [18:0]        target_reg [VOICES];
    logic [34:0]        glide_reg  [VOICES];
    logic [16:0]        env_reg    [VOICES];
    logic [23:0]        phase_reg  [VOICES];
    logic signed [17:0] lp_reg     [VOICES];

    // sequencer working registers
    logic [VW-1:0]      voice_reg, voice_next;
    logic signed [23:0] mix_reg, mix_next;
    logic signed [19:0] lpdiff_reg, lpdiff_next;
    logic [23:0]        mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [14:0]        ymag_reg, ymag_next;
    logic signed [15:0] sample_reg, sample_next;
    logic               out_valid_reg, out_valid_next;

    // shared multiplier
    logic signed [pss_pkg::MUL_A_W-1:0] mul_a;
    logic signed [pss_pkg::MUL_B_W-1:0] mul_b;
    logic signed [pss_pkg::MUL_P_W-1:0] prod;

    pss_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // handshakes
    logic item_acc, note_ok, last_voice;
    assign item_ready   = (state_reg == S_IDLE);
    assign item_acc     = item_valid && item_ready;
    assign cfg_ready    = 1'b1;
    assign sample_valid = out_valid_reg;
    assign sample       = sample_reg;
    assign note_ok      = ({1'b0, track} < 5'(VOICES));
    assign last_voice   = (voice_reg == VW'(VOICES - 1));

    // current voice values
    logic               cur_gate;
    logic [18:0]        cur_target;
    logic [34:0]        cur_glide;
    logic [16:0]        cur_env;
    logic [23:0]        cur_phase;
    logic signed [17:0] cur_lp;
    assign cur_gate   = gate_reg[voice_reg];
    assign cur_target = target_reg[voice_reg];
    assign cur_glide  = glide_reg[voice_reg];
    assign cur_env    = env_reg[voice_reg];
    assign cur_phase  = phase_reg[voice_reg];
    assign cur_lp     = lp_reg[voice_reg];

    // glide difference and update
    logic signed [35:0] glide_diff;
    logic [35:0]        glide_sum;
    assign glide_diff = $signed({1'b0, cur_target, 16'd0}) - $signed({1'b0, cur_glide});
    assign glide_sum  = {1'b0, cur_glide} + prod[51:16];

    // envelope update
    logic [17:0] env_up;
    logic [16:0] env_new;
    assign env_up = {1'b0, cur_env} + {2'd0, attack_reg};
    always_comb
    begin
        if (cur_gate)
        begin
            env_new = (env_up > {1'b0, pss_pkg::ENV_ONE}) ? pss_pkg::ENV_ONE : env_up[16:0];
        end
        else
        begin
            env_new = (cur_env > {1'b0, release_reg}) ? (cur_env - {1'b0, release_reg}) : 17'd0;
        end
    end

    // waveform: phase >> 7 minus one half turn flips the top bit
    logic signed [16:0] saw;
    logic signed [18:0] square, raw;
    assign saw    = $signed({~cur_phase[23], cur_phase[22:7]});
    assign square = cur_phase[23] ? -$signed(pss_pkg::SQUARE_AMP) : $signed(pss_pkg::SQUARE_AMP);
    assign raw    = square + prod[34:16];

    // soft clip table step
    logic [5:0]  clip_i;
    logic [14:0] tab_lo, tab_hi;
    logic        clip_sat;
    assign clip_i   = mag_reg[18:13];
    assign clip_sat = (mag_reg[23:18] != 6'd0);
    assign tab_lo   = pss_pkg::tanh_lut(clip_i);
    assign tab_hi   = pss_pkg::tanh_lut(clip_i + 6'd1);

    // multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_GLIDE:
            begin
                mul_a = glide_diff;
                mul_b = pss_pkg::GLIDE_COEF;
            end
            S_STEP:
            begin
                mul_a = $signed({1'b0, cur_glide});
                mul_b = $signed({1'b0, hz_reg});
            end
            S_SAW:
            begin
                mul_a = 36'(saw);
                mul_b = pss_pkg::SAW_GAIN;
            end
            S_LPMUL:
            begin
                mul_a = 36'(lpdiff_reg);
                mul_b = $signed({9'd0, alpha_reg});
            end
            S_MIXMUL:
            begin
                mul_a = 36'(cur_lp);
                mul_b = $signed({8'd0, cur_env});
            end
            S_CLIPMUL:
            begin
                mul_a = $signed({21'd0, tab_hi - tab_lo});
                mul_b = $signed({12'd0, mag_reg[12:0]});
            end
            // volume product is held while the output waits
            S_VOL, S_OUT:
            begin
                mul_a = $signed({21'd0, ymag_reg});
                mul_b = $signed({9'd0, volume_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        voice_next     = voice_reg;
        mix_next       = mix_reg;
        lpdiff_next    = lpdiff_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        ymag_next      = ymag_reg;
        sample_next    = sample_reg;
        out_valid_next = out_valid_reg && !sample_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (item_acc && operation == pss_pkg::OP_TICK)
                begin
                    voice_next = '0;
                    mix_next   = '0;
                    state_next = S_GLIDE;
                end
            end
            S_GLIDE:
            begin
                state_next = S_ENV;
            end
            S_ENV:
            begin
                if (env_new > pss_pkg::ENV_THRESHOLD)
                begin
                    state_next = S_STEP;
                end
                else if (last_voice)
                begin
                    state_next = S_CLIP;
                end
                else
                begin
                    voice_next = voice_reg + VW'(1);
                    state_next = S_GLIDE;
                end
            end
            S_STEP:
            begin
                state_next = S_PHASE;
            end
            S_PHASE:
            begin
                state_next = S_SAW;
            end
            S_SAW:
            begin
                state_next = S_RAW;
            end
            S_RAW:
            begin
                lpdiff_next = 20'(raw) - 20'(cur_lp);
                state_next  = S_LPMUL;
            end
            S_LPMUL:
            begin
                state_next = S_LPUPD;
            end
            S_LPUPD:
            begin
                state_next = S_MIXMUL;
            end
            S_MIXMUL:
            begin
                state_next = S_MIXACC;
            end
            S_MIXACC:
            begin
                mix_next = mix_reg + prod[39:16];
                if (last_voice)
                begin
                    state_next = S_CLIP;
                end
                else
                begin
                    voice_next = voice_reg + VW'(1);
                    state_next = S_GLIDE;
                end
            end
            S_CLIP:
            begin
                neg_next   = mix_reg[23];
                mag_next   = mix_reg[23] ? 24'(-mix_reg) : mix_reg;
                state_next = S_CLIPMUL;
            end
            S_CLIPMUL:
            begin
                state_next = S_CLIPY;
            end
            S_CLIPY:
            begin
                ymag_next  = clip_sat ? pss_pkg::CLIP_MAX : (tab_lo + prod[26:13] );
                state_next = S_VOL;
            end
            S_VOL:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || sample_ready)
                begin
                    sample_next    = neg_reg ? -$signed({1'b0, prod[30:16]})
                                             : $signed({1'b0, prod[30:16]});
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            voice_reg     <= '0;
            mix_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            voice_reg     <= voice_next;
            mix_reg       <= mix_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        lpdiff_reg <= lpdiff_next;
        mag_reg    <= mag_next;
        neg_reg    <= neg_next;
        ymag_reg   <= ymag_next;
        sample_reg <= sample_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= pss_pkg::ATTACK_RST;
            release_reg <= pss_pkg::RELEASE_RST;
            alpha_reg   <= pss_pkg::ALPHA_RST;
            hz_reg      <= pss_pkg::HZ_RST;
            volume_reg  <= pss_pkg::VOLUME_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pss_pkg::REG_ATTACK:  attack_reg  <= cfg_data[15:0];
                pss_pkg::REG_RELEASE: release_reg <= cfg_data[15:0];
                pss_pkg::REG_ALPHA:   alpha_reg   <= cfg_data[15:0];
                pss_pkg::REG_HZ:      hz_reg      <= cfg_data;
                pss_pkg::REG_VOLUME:  volume_reg  <= cfg_data[15:0];
                default:              ;
            endcase
        end
    end

    // voice state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < VOICES; k++)
            begin
                gate_reg[k]   <= 1'b0;
                target_reg[k] <= '0;
                glide_reg[k]  <= '0;
                env_reg[k]    <= '0;
                phase_reg[k]  <= '0;
                lp_reg[k]     <= '0;
            end
        end
        else
        begin
            // note on and note off
            if (item_acc && note_ok)
            begin
                if (operation == pss_pkg::OP_NOTE_ON)
                begin
                    target_reg[track[VW-1:0]] <= frequency;
                    gate_reg[track[VW-1:0]]   <= 1'b1;
                end
                else if (operation == pss_pkg::OP_NOTE_OFF)
                begin
                    gate_reg[track[VW-1:0]] <= 1'b0;
                end
            end
            // glide and envelope
            if (state_reg == S_ENV)
            begin
                glide_reg[voice_reg] <= glide_sum[34:0];
                env_reg[voice_reg]   <= env_new;
                if (env_new <= pss_pkg::ENV_THRESHOLD)
                begin
                    phase_reg[voice_reg] <= '0;
                end
            end
            // phase advance
            if (state_reg == S_PHASE)
            begin
                phase_reg[voice_reg] <= cur_phase + prod[55:32];
            end
            // lowpass update
            if (state_reg == S_LPUPD)
            begin
                lp_reg[voice_reg] <= cur_lp + prod[33:16];
            end
        end
    end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// self-checking bench for polyphonic_square_saw_synth: random and directed notes and ticks
// depends on pss_pkg and the synth rtl; predicts every sample with its own voice model
module tb;

    localparam int NV = 8;
    localparam int STALL_LIMIT = 5000;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  trk;
        logic [18:0] freq;
    } note_item_t;

    typedef struct packed {
        logic [pss_pkg::CFG_IDX_W-1:0]  idx;
        logic [pss_pkg::CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_ready;
    logic [1:0] operation;
    logic [3:0] track;
    logic [18:0] frequency;
    logic sample_valid;
    logic sample_ready;
    logic signed [15:0] sample;
    logic cfg_valid;
    logic cfg_ready;
    logic [pss_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [pss_pkg::CFG_DATA_W-1:0] cfg_data;

    note_item_t pending_notes[$];
    reg_write_t pending_writes[$];
    logic signed [15:0] expected_samples[$];
    int err_count;
    int stall_cycles;
    logic calm;

    // voice model state and register copies
    logic   gate[NV] = '{default: 1'b0};
    longint tgt[NV];
    longint glide[NV];
    longint env[NV];
    longint ph[NV];
    longint lp[NV];
    longint attack_r = pss_pkg::ATTACK_RST;
    longint release_r = pss_pkg::RELEASE_RST;
    longint alpha_r = pss_pkg::ALPHA_RST;
    longint hz_r = pss_pkg::HZ_RST;
    longint volume_r = pss_pkg::VOLUME_RST;
    longint tanh_t[33] = '{0, 4075, 8025, 11743, 15143, 18173, 20813, 23066,
                           24956, 26519, 27797, 28830, 29660, 30322, 30847, 31262,
                           31589, 31846, 32048, 32206, 32329, 32426, 32500, 32560,
                           32606, 32642, 32670, 32691, 32708, 32722, 32732, 32740,
                           32746};

    polyphonic_square_saw_synth u_dut (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_ready(item_ready),
        .operation(operation), .track(track), .frequency(frequency),
        .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // one sample tick over all voices, returns the output sample
    function automatic logic signed [15:0] synth_tick();
        longint mix, diff, step, sq, saw, raw, m, i, f, y, mag, o;
        mix = 0;
        for (int v = 0; v < NV; v++)
        begin
            diff = (tgt[v] << 16) - glide[v];
            glide[v] = glide[v] + ((diff * 328) >>> 16);
            if (gate[v])
                env[v] = (env[v] + attack_r > 65536) ? 65536 : env[v] + attack_r;
            else
                env[v] = (env[v] > release_r) ? env[v] - release_r : 0;
            if (env[v] > 6)
            begin
                step = (glide[v] * hz_r) >> 32;
                ph[v] = (ph[v] + step) & 64'hFFFFFF;
                sq = (ph[v] < 64'h800000) ? 45875 : -45875;
                saw = (ph[v] >> 7) - 65536;
                raw = sq + ((saw * 19661) >>> 16);
                lp[v] = lp[v] + ((alpha_r * (raw - lp[v])) >>> 16);
                mix += (lp[v] * env[v]) >>> 16;
            end
            else
                ph[v] = 0;
        end
        m = (mix < 0) ? -mix : mix;
        i = m >> 13;
        f = m & 8191;
        if (i >= 32)
            y = 32767;
        else
            y = tanh_t[i] + (((tanh_t[i+1] - tanh_t[i]) * f) >>> 13);
        mag = (y * volume_r) >> 16;
        o = (mix < 0) ? -mag : mag;
        return o[15:0];
    endfunction

    // item driver: applies accepted items to the model, presents the next one
    always @(posedge clk or negedge rst_n)
    begin
        logic nv;
        note_item_t it;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            nv = item_valid;
            if (item_valid && item_ready)
            begin
                nv = 1'b0;
                if (operation == pss_pkg::OP_TICK)
                    expected_samples.push_back(synth_tick());
                else if (operation == pss_pkg::OP_NOTE_ON && track < NV)
                begin
                    tgt[track] = frequency;
                    gate[track] = 1'b1;
                end
                else if (operation == pss_pkg::OP_NOTE_OFF && track < NV)
                    gate[track] = 1'b0;
            end
            if (!nv && pending_notes.size() > 0 && (calm || $urandom_range(99) >= 25))
            begin
                it = pending_notes.pop_front();
                operation <= it.op;
                track <= it.trk;
                frequency <= it.freq;
                nv = 1'b1;
            end
            item_valid <= nv;
        end
    end

    // register write driver
    always @(posedge clk or negedge rst_n)
    begin
        logic nv;
        reg_write_t w;
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
        end
        else
        begin
            nv = cfg_valid;
            if (cfg_valid && cfg_ready)
            begin
                nv = 1'b0;
                case (cfg_index)
                    pss_pkg::REG_ATTACK:  attack_r = cfg_data[15:0];
                    pss_pkg::REG_RELEASE: release_r = cfg_data[15:0];
                    pss_pkg::REG_ALPHA:   alpha_r = cfg_data[15:0];
                    pss_pkg::REG_HZ:      hz_r = cfg_data[23:0];
                    pss_pkg::REG_VOLUME:  volume_r = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (!nv && pending_writes.size() > 0 && (calm || $urandom_range(99) >= 25))
            begin
                w = pending_writes.pop_front();
                cfg_index <= w.idx;
                cfg_data <= w.data;
                nv = 1'b1;
            end
            cfg_valid <= nv;
        end
    end

    // sample monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        logic signed [15:0] e;
        if (!rst_n)
        begin
            sample_ready <= 1'b0;
        end
        else
        begin
            if (sample_valid && sample_ready)
            begin
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: unexpected sample item %0d", $time, sample);
                    err_count++;
                end
                else
                begin
                    e = expected_samples.pop_front();
                    if (e !== sample)
                    begin
                        $display("%0t: sample expected %0d actual %0d", $time, e, sample);
                        err_count++;
                    end
                end
            end
            sample_ready <= calm || ($urandom_range(99) >= 25);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (sample_valid && sample_ready)
            || (cfg_valid && cfg_ready) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic add_note(input logic [1:0] op, input logic [3:0] trk,
                            input logic [18:0] freq);
        note_item_t it;
        it.op = op;
        it.trk = trk;
        it.freq = freq;
        pending_notes.push_back(it);
    endtask

    task automatic add_write(input logic [pss_pkg::CFG_IDX_W-1:0] idx,
                             input logic [23:0] data);
        reg_write_t w;
        w.idx = idx;
        w.data = data;
        pending_writes.push_back(w);
    endtask

    // random well-formed traffic with some ignored items mixed in
    task automatic add_random(input int n);
        int r;
        logic [18:0] fq;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            fq = ($urandom_range(9) == 0) ? 19'($urandom) : 19'($urandom_range(327680));
            if (r < 50)
                add_note(pss_pkg::OP_TICK, 4'($urandom), 19'($urandom));
            else if (r < 75)
                add_note(pss_pkg::OP_NOTE_ON, 4'($urandom_range(NV - 1)), fq);
            else if (r < 90)
                add_note(pss_pkg::OP_NOTE_OFF, 4'($urandom_range(NV - 1)), 19'($urandom));
            else if (r < 95)
                add_note(2'($urandom_range(2, 1)), 4'($urandom_range(15, NV)), fq);
            else
                add_note(2'd3, 4'($urandom), 19'($urandom));
        end
    endtask

    task automatic drain();
        while (pending_notes.size() > 0 || item_valid || expected_samples.size() > 0
               || pending_writes.size() > 0 || cfg_valid)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_all(input logic [15:0] a, input logic [15:0] rl,
                             input logic [15:0] al, input logic [23:0] hz,
                             input logic [15:0] vol);
        add_write(pss_pkg::REG_ATTACK, {8'($urandom), a});
        add_write(pss_pkg::REG_RELEASE, {8'($urandom), rl});
        add_write(pss_pkg::REG_ALPHA, {8'($urandom), al});
        add_write(pss_pkg::REG_HZ, hz);
        add_write(pss_pkg::REG_VOLUME, {8'($urandom), vol});
        add_write(pss_pkg::CFG_IDX_W'($urandom_range(7, 5)), 24'($urandom));
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        calm = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, ignored tracks, unused op, note off
        add_note(pss_pkg::OP_TICK, 4'd0, 19'd0);
        add_note(pss_pkg::OP_NOTE_ON, 4'd0, 19'd0);
        add_note(pss_pkg::OP_NOTE_ON, 4'd7, 19'h7FFFF);
        add_note(pss_pkg::OP_NOTE_ON, 4'd3, 19'd327680);
        add_note(pss_pkg::OP_NOTE_ON, 4'd15, 19'd7040);
        add_note(pss_pkg::OP_NOTE_OFF, 4'd8, 19'd0);
        add_note(2'd3, 4'd15, 19'h7FFFF);
        add_note(pss_pkg::OP_TICK, 4'd15, 19'h7FFFF);
        add_note(pss_pkg::OP_TICK, 4'd0, 19'd0);
        add_note(pss_pkg::OP_NOTE_ON, 4'd5, 19'd7040);
        add_note(pss_pkg::OP_TICK, 4'd0, 19'd0);
        add_note(pss_pkg::OP_NOTE_OFF, 4'd0, 19'd0);
        add_note(pss_pkg::OP_NOTE_OFF, 4'd7, 19'd0);
        add_note(pss_pkg::OP_TICK, 4'd0, 19'd0);
        add_note(pss_pkg::OP_TICK, 4'd0, 19'd0);
        drain();

        // fast envelopes at full scale: full gain, huge phase steps
        write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 16'hFFFF);
        add_random(250);
        drain();

        // slowest corner: no filter movement, no phase step, silent output
        write_all(16'd1, 16'd1, 16'd0, 24'd0, 16'd0);
        add_random(150);
        drain();

        // zero envelope steps hold the level; no idling in this stretch
        calm = 1'b1;
        write_all(16'd0, 16'd0, 16'($urandom), 24'($urandom), 16'($urandom));
        add_random(150);
        drain();
        calm = 1'b0;

        // random settings with quick attack so voices sound
        for (int p = 0; p < 4; p++)
        begin
            write_all(16'($urandom_range(65535, 2000)), 16'($urandom_range(65535, 1)),
                      16'($urandom), 24'($urandom), 16'($urandom));
            add_random(250);
            drain();
        end

        // back to reset values
        write_all(pss_pkg::ATTACK_RST, pss_pkg::RELEASE_RST, pss_pkg::ALPHA_RST,
                  pss_pkg::HZ_RST, pss_pkg::VOLUME_RST);
        add_random(1);
        drain();

        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
